// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ADB responder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside reset.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/adb_pkg.sv -----
// ----------------------------------------------------------------------------
// ADB responder package
// Types, codes and reset constants shared by the ADB responder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adb_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Transaction modes
   localparam logic [1:0] MODE_BUS     = 2'd0;
   localparam logic [1:0] MODE_PRESS   = 2'd1;
   localparam logic [1:0] MODE_RELEASE = 2'd2;

   // Bus command codes and register numbers
   localparam logic [1:0] CMD_LISTEN = 2'd2;
   localparam logic [1:0] CMD_TALK   = 2'd3;
   localparam logic [1:0] REG_ONE    = 2'd1;
   localparam logic [1:0] REG_TWO    = 2'd2;
   localparam logic [1:0] REG_THREE  = 2'd3;

   // Reset values
   localparam logic [7:0]  KEYBOARD_TYPE_RESET = 8'h05;
   localparam logic [7:0]  MOUSE_ADDR_RESET    = 8'h63;
   localparam logic [7:0]  MOUSE_HANDLER_RESET = 8'h01;
   localparam logic [15:0] KBD_LED_RESET       = 16'hffff;
   localparam logic [7:0]  KBD_ADDR_RESET      = 8'h62;

   // Register 3 listen codes
   localparam logic [7:0] LISTEN_ADDR_ONLY  = 8'hfe;
   localparam logic [7:0] LISTEN_ADDR_FLAGS = 8'h00;
   localparam logic [7:0] HANDLER_ONE       = 8'h01;
   localparam logic [7:0] HANDLER_TWO       = 8'h02;
   localparam logic [7:0] HANDLER_FOUR      = 8'h04;
   localparam logic [7:0] ADDR_KEEP_MASK    = 8'hd0;
   localparam logic [7:0] ADDR_SET_MASK     = 8'h2f;
   localparam logic [7:0] LED_FORCE_MASK    = 8'hf8;

   // Modifier and LED keycodes
   localparam logic [6:0] KEY_COMMAND = 7'h37;
   localparam logic [6:0] KEY_OPTION  = 7'h3a;
   localparam logic [6:0] KEY_SHIFT   = 7'h38;
   localparam logic [6:0] KEY_CONTROL = 7'h36;
   localparam logic [6:0] KEY_CAPS    = 7'h39;
   localparam logic [6:0] KEY_DELETE  = 7'h75;
   localparam logic [6:0] KEY_SCROLL  = 7'h6b;
   localparam logic [6:0] KEY_NUMLOCK = 7'h47;

   // Reply lengths
   localparam logic [3:0] REPLY_NONE = 4'd0;
   localparam logic [3:0] REPLY_REG  = 4'd2;
   localparam logic [3:0] REPLY_ID   = 4'd8;

   // Mouse identification record, byte 0 at index 0
   localparam logic [7:0][7:0] MOUSE_ID_RECORD = {
      8'h03, 8'h01, 8'h2c, 8'h01, 8'h6c, 8'h70, 8'h70, 8'h61
   };

   typedef enum logic [3:0] {
      OP_NONE,
      OP_KEY_DOWN,
      OP_KEY_UP,
      OP_DEV_RESET,
      OP_LISTEN_R2,
      OP_LISTEN_R3,
      OP_TALK_R1,
      OP_TALK_R2,
      OP_TALK_R3
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [3:0]  adr;
      logic [7:0]  hi;
      logic [7:0]  lo;
      logic [6:0]  key;
      logic [3:0]  rnd;
   } cmd_entry_type;

   typedef struct packed {
      logic          push;
      cmd_entry_type entry;
   } push_type;

   typedef struct packed {
      logic [3:0]       count;
      logic [7:0][7:0]  bytes;
   } reply_type;

endpackage

// ----- design/adb_if.sv -----
// ----------------------------------------------------------------------------
// ADB responder channels
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface adb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] command_byte;
   logic [7:0] listen_high;
   logic [7:0] listen_low;
   logic [6:0] key_number;
   logic [3:0] random_nibble;

   modport source (output valid, mode, command_byte, listen_high, listen_low,
                   key_number, random_nibble, input ready);
   modport sink   (input valid, mode, command_byte, listen_high, listen_low,
                   key_number, random_nibble, output ready);
endinterface

interface adb_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] reply_count;
   logic [7:0] reply_byte_0;
   logic [7:0] reply_byte_1;
   logic [7:0] reply_byte_2;
   logic [7:0] reply_byte_3;
   logic [7:0] reply_byte_4;
   logic [7:0] reply_byte_5;
   logic [7:0] reply_byte_6;
   logic [7:0] reply_byte_7;

   modport source (output valid, reply_count, reply_byte_0, reply_byte_1,
                   reply_byte_2, reply_byte_3, reply_byte_4, reply_byte_5,
                   reply_byte_6, reply_byte_7, input ready);
   modport sink   (input valid, reply_count, reply_byte_0, reply_byte_1,
                   reply_byte_2, reply_byte_3, reply_byte_4, reply_byte_5,
                   reply_byte_6, reply_byte_7, output ready);
endinterface

// ----- design/adb_front.sv -----
// ----------------------------------------------------------------------------
// ADB responder front end
// Accepts request transactions and decodes them into queue entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adb_front (
   adb_req_if.sink          req_ch,
   input  logic             q_full,
   output adb_pkg::push_type push_out
);

   adb_pkg::op_kind_type kind;
   logic [1:0]           cmd;
   logic [1:0]           rsel;

   assign cmd  = req_ch.command_byte[3:2];
   assign rsel = req_ch.command_byte[1:0];

   always_comb begin
      kind = adb_pkg::OP_NONE;
      case (req_ch.mode)
         adb_pkg::MODE_PRESS:   kind = adb_pkg::OP_KEY_DOWN;
         adb_pkg::MODE_RELEASE: kind = adb_pkg::OP_KEY_UP;
         adb_pkg::MODE_BUS: begin
            if (req_ch.command_byte[3:0] == 4'd0) begin
               kind = adb_pkg::OP_DEV_RESET;
            end else if (cmd == adb_pkg::CMD_LISTEN && rsel == adb_pkg::REG_TWO) begin
               kind = adb_pkg::OP_LISTEN_R2;
            end else if (cmd == adb_pkg::CMD_LISTEN && rsel == adb_pkg::REG_THREE) begin
               kind = adb_pkg::OP_LISTEN_R3;
            end else if (cmd == adb_pkg::CMD_TALK && rsel == adb_pkg::REG_ONE) begin
               kind = adb_pkg::OP_TALK_R1;
            end else if (cmd == adb_pkg::CMD_TALK && rsel == adb_pkg::REG_TWO) begin
               kind = adb_pkg::OP_TALK_R2;
            end else if (cmd == adb_pkg::CMD_TALK && rsel == adb_pkg::REG_THREE) begin
               kind = adb_pkg::OP_TALK_R3;
            end
         end
         default: kind = adb_pkg::OP_NONE;
      endcase
   end

   assign req_ch.ready         = !q_full;
   assign push_out.push        = req_ch.valid && !q_full;
   assign push_out.entry.kind  = kind;
   assign push_out.entry.adr   = req_ch.command_byte[7:4];
   assign push_out.entry.hi    = req_ch.listen_high;
   assign push_out.entry.lo    = req_ch.listen_low;
   assign push_out.entry.key   = req_ch.key_number;
   assign push_out.entry.rnd   = req_ch.random_nibble;

endmodule

// ----- design/adb_queue.sv -----
// ----------------------------------------------------------------------------
// ADB responder command queue
// Short FIFO of decoded transactions between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adb_queue #(
   parameter int DEPTH = adb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  adb_pkg::push_type      push_in,
   input  logic                   pop,
   output logic                   full,
   output logic                   empty,
   output adb_pkg::cmd_entry_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   adb_pkg::cmd_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff,  count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push_in.push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

endmodule

// ----- design/adb_back.sv -----
// ----------------------------------------------------------------------------
// ADB responder back end
// Executes queued transactions on the device registers and key matrix and
// holds the reply in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             keyboard_type,
   input  logic                   q_empty,
   input  adb_pkg::cmd_entry_type head,
   output logic                   pop,
   adb_rsp_if.source              rsp_ch
);

   logic [7:0]         mouse_addr_ff,    mouse_addr_in;
   logic [7:0]         mouse_handler_ff, mouse_handler_in;
   logic [15:0]        kbd_led_ff,       kbd_led_in;
   logic [7:0]         kbd_addr_ff,      kbd_addr_in;
   logic [7:0]         kbd_handler_ff,   kbd_handler_in;
   logic [127:0]       key_matrix_ff,    key_matrix_in;
   logic               rsp_valid_ff,     rsp_valid_in;
   adb_pkg::reply_type reply_ff,         reply_in;

   logic       mouse_hit;
   logic       kbd_hit;
   logic [7:0] mod_high;
   logic [7:0] mod_low;

   function automatic logic [7:0] listen_addr(input logic [7:0] cur,
                                              input logic [7:0] hi,
                                              input logic [7:0] lo);
      logic [7:0] res;
      res = cur;
      if (lo == adb_pkg::LISTEN_ADDR_ONLY) begin
         res = {cur[7:4], hi[3:0]};
      end else if (lo == adb_pkg::LISTEN_ADDR_FLAGS) begin
         res = (cur & adb_pkg::ADDR_KEEP_MASK) | (hi & adb_pkg::ADDR_SET_MASK);
      end
      return res;
   endfunction

   assign pop       = !q_empty && (!rsp_valid_ff || rsp_ch.ready);
   assign mouse_hit = (head.adr == mouse_addr_ff[3:0]);
   assign kbd_hit   = !mouse_hit && (head.adr == kbd_addr_ff[3:0]);

   always_comb begin
      mod_high    = 8'hff;
      mod_high[0] = !key_matrix_ff[adb_pkg::KEY_COMMAND];
      mod_high[1] = !key_matrix_ff[adb_pkg::KEY_OPTION];
      mod_high[2] = !key_matrix_ff[adb_pkg::KEY_SHIFT];
      mod_high[3] = !key_matrix_ff[adb_pkg::KEY_CONTROL];
      mod_high[5] = !key_matrix_ff[adb_pkg::KEY_CAPS];
      mod_high[6] = !key_matrix_ff[adb_pkg::KEY_DELETE];
      mod_low     = kbd_led_ff[7:0] | adb_pkg::LED_FORCE_MASK;
      mod_low[6]  = !key_matrix_ff[adb_pkg::KEY_SCROLL];
      mod_low[7]  = !key_matrix_ff[adb_pkg::KEY_NUMLOCK];
   end

   always_comb begin
      mouse_addr_in    = mouse_addr_ff;
      mouse_handler_in = mouse_handler_ff;
      kbd_led_in       = kbd_led_ff;
      kbd_addr_in      = kbd_addr_ff;
      kbd_handler_in   = kbd_handler_ff;
      key_matrix_in    = key_matrix_ff;
      reply_in         = reply_ff;
      rsp_valid_in     = rsp_ch.ready ? 1'b0 : rsp_valid_ff;

      if (pop) begin
         rsp_valid_in   = 1'b1;
         reply_in.count = adb_pkg::REPLY_NONE;
         reply_in.bytes = '0;
         case (head.kind)
            adb_pkg::OP_KEY_DOWN: key_matrix_in[head.key] = 1'b1;
            adb_pkg::OP_KEY_UP:   key_matrix_in[head.key] = 1'b0;
            adb_pkg::OP_DEV_RESET: begin
               mouse_addr_in    = adb_pkg::MOUSE_ADDR_RESET;
               mouse_handler_in = adb_pkg::MOUSE_HANDLER_RESET;
               kbd_led_in       = adb_pkg::KBD_LED_RESET;
               kbd_addr_in      = adb_pkg::KBD_ADDR_RESET;
               kbd_handler_in   = keyboard_type;
            end
            adb_pkg::OP_LISTEN_R2: begin
               if (kbd_hit) begin
                  kbd_led_in = {head.hi, head.lo};
               end
            end
            adb_pkg::OP_LISTEN_R3: begin
               if (mouse_hit) begin
                  if (head.lo == adb_pkg::HANDLER_ONE || head.lo == adb_pkg::HANDLER_TWO ||
                      head.lo == adb_pkg::HANDLER_FOUR) begin
                     mouse_handler_in = head.lo;
                  end else begin
                     mouse_addr_in = listen_addr(mouse_addr_ff, head.hi, head.lo);
                  end
               end else if (kbd_hit) begin
                  kbd_addr_in = listen_addr(kbd_addr_ff, head.hi, head.lo);
               end
            end
            adb_pkg::OP_TALK_R1: begin
               if (mouse_hit) begin
                  reply_in.count = adb_pkg::REPLY_ID;
                  reply_in.bytes = adb_pkg::MOUSE_ID_RECORD;
               end
            end
            adb_pkg::OP_TALK_R2: begin
               if (kbd_hit) begin
                  reply_in.count    = adb_pkg::REPLY_REG;
                  reply_in.bytes[0] = mod_high;
                  reply_in.bytes[1] = mod_low;
               end
            end
            adb_pkg::OP_TALK_R3: begin
               if (mouse_hit) begin
                  reply_in.count    = adb_pkg::REPLY_REG;
                  reply_in.bytes[0] = {mouse_addr_ff[7:4], head.rnd};
                  reply_in.bytes[1] = mouse_handler_ff;
               end else if (kbd_hit) begin
                  reply_in.count    = adb_pkg::REPLY_REG;
                  reply_in.bytes[0] = {kbd_addr_ff[7:4], head.rnd};
                  reply_in.bytes[1] = kbd_handler_ff;
               end
            end
            default: reply_in.count = adb_pkg::REPLY_NONE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mouse_addr_ff    <= adb_pkg::MOUSE_ADDR_RESET;
         mouse_handler_ff <= adb_pkg::MOUSE_HANDLER_RESET;
         kbd_led_ff       <= adb_pkg::KBD_LED_RESET;
         kbd_addr_ff      <= adb_pkg::KBD_ADDR_RESET;
         kbd_handler_ff   <= adb_pkg::KEYBOARD_TYPE_RESET;
         key_matrix_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         mouse_addr_ff    <= mouse_addr_in;
         mouse_handler_ff <= mouse_handler_in;
         kbd_led_ff       <= kbd_led_in;
         kbd_addr_ff      <= kbd_addr_in;
         kbd_handler_ff   <= kbd_handler_in;
         key_matrix_ff    <= key_matrix_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reply_ff <= reply_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.reply_count  = reply_ff.count;
   assign rsp_ch.reply_byte_0 = reply_ff.bytes[0];
   assign rsp_ch.reply_byte_1 = reply_ff.bytes[1];
   assign rsp_ch.reply_byte_2 = reply_ff.bytes[2];
   assign rsp_ch.reply_byte_3 = reply_ff.bytes[3];
   assign rsp_ch.reply_byte_4 = reply_ff.bytes[4];
   assign rsp_ch.reply_byte_5 = reply_ff.bytes[5];
   assign rsp_ch.reply_byte_6 = reply_ff.bytes[6];
   assign rsp_ch.reply_byte_7 = reply_ff.bytes[7];

endmodule

// ----- design/adb_device_command_responder.sv -----
// ----------------------------------------------------------------------------
// ADB device command responder
// Combined ADB mouse and keyboard device: bus commands and key events in,
// one reply transaction out per request. The front end decodes each request
// and pushes it into a QUEUE_DEPTH-entry queue; the back end takes one entry
// per cycle unless a held reply blocks it, updates the device registers and
// the 128-key matrix, and loads the reply register. One request is accepted
// per cycle while the queue is not full; its reply goes through the queue
// and then the reply register, which absorb response-side stalls. The user
// must write the keyboard type register through the csr port only while no
// transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adb_device_command_responder #(
   parameter int QUEUE_DEPTH = adb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   adb_req_if.sink    req_ch,
   adb_rsp_if.source  rsp_ch
);

   logic [7:0]             keyboard_type_ff;
   adb_pkg::push_type      push;
   adb_pkg::cmd_entry_type head;
   logic                   q_full;
   logic                   q_empty;
   logic                   pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         keyboard_type_ff <= adb_pkg::KEYBOARD_TYPE_RESET;
      end else if (csr_wr_en) begin
         keyboard_type_ff <= csr_wr_data;
      end
   end

   adb_front u_front (
      .req_ch   (req_ch),
      .q_full   (q_full),
      .push_out (push)
   );

   adb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .full    (q_full),
      .empty   (q_empty),
      .head    (head)
   );

   adb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .keyboard_type (keyboard_type_ff),
      .q_empty       (q_empty),
      .head          (head),
      .pop           (pop),
      .rsp_ch        (rsp_ch)
   );

endmodule

// ----- design/adb_checker.sv -----
// ----------------------------------------------------------------------------
// ADB responder checker
// Port-level assertions on the responder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] reply_count,
   input logic [7:0] reply_byte_2,
   input logic [7:0] reply_byte_3,
   input logic [7:0] reply_byte_4,
   input logic [7:0] reply_byte_5,
   input logic [7:0] reply_byte_6,
   input logic [7:0] reply_byte_7
);

   logic stalled;
   logic count_legal;
   logic short_reply;
   logic tail_zero;
   logic idle;

   assign stalled     = rsp_valid && !rsp_ready;
   assign count_legal = (reply_count == adb_pkg::REPLY_NONE) ||
                        (reply_count == adb_pkg::REPLY_REG) ||
                        (reply_count == adb_pkg::REPLY_ID);
   assign short_reply = rsp_valid && (reply_count != adb_pkg::REPLY_ID);
   assign tail_zero   = ({reply_byte_7, reply_byte_6, reply_byte_5, reply_byte_4,
                          reply_byte_3, reply_byte_2} == '0);
   assign idle        = !rsp_valid && req_ready;

   `ASSERT_CLKD(a_rsp_hold, clock, reset, stalled |=> rsp_valid, "reply dropped in stall")

   `ASSERT_CLKD(a_count_legal, clock, reset, rsp_valid |-> count_legal, "illegal reply count")

   `ASSERT_CLKD(a_tail_zero, clock, reset, short_reply |-> tail_zero, "nonzero reply tail")

   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> idle, "not idle after reset")

endmodule

bind adb_device_command_responder adb_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .reply_count  (rsp_ch.reply_count),
   .reply_byte_2 (rsp_ch.reply_byte_2),
   .reply_byte_3 (rsp_ch.reply_byte_3),
   .reply_byte_4 (rsp_ch.reply_byte_4),
   .reply_byte_5 (rsp_ch.reply_byte_5),
   .reply_byte_6 (rsp_ch.reply_byte_6),
   .reply_byte_7 (rsp_ch.reply_byte_7)
);

// ----- tb/sv/adb_device_command_responder_test.sv -----
// ----------------------------------------------------------------------------
// ADB device command responder testbench
// Drives bus commands and key events into the responder, predicts every reply
// from a local model of the mouse and keyboard registers and the key matrix,
// and checks each reply in order. Covers directed corner cases, random
// command streams, changing keyboard types, idling on both sides and a long
// response hold-off that backs up the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adb_device_command_responder_test;

   localparam logic [1:0] MODE_UNUSED  = 2'd3;
   localparam logic [1:0] CMD_FLUSH    = 2'd0;
   localparam logic [1:0] CMD_RESERVED = 2'd1;
   localparam logic [1:0] REG_ZERO     = 2'd0;
   localparam int         RANDOM_ITEMS = 450;
   localparam int         FEED_AHEAD   = 4;
   localparam int         LONG_HOLD    = 400;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         PRINT_LIMIT  = 40;
   localparam logic [6:0] MODIFIER_KEYS [8] = '{
      adb_pkg::KEY_COMMAND, adb_pkg::KEY_OPTION, adb_pkg::KEY_SHIFT, adb_pkg::KEY_CONTROL,
      adb_pkg::KEY_CAPS, adb_pkg::KEY_DELETE, adb_pkg::KEY_SCROLL, adb_pkg::KEY_NUMLOCK
   };

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] command;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [6:0] key;
      logic [3:0] rnd;
   } bus_event_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [7:0] csr_wr_data;

   adb_req_if req_if ();
   adb_rsp_if rsp_if ();

   adb_device_command_responder dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if)
   );

   // local copy of the device state
   logic [7:0]   kbd_type;
   logic [7:0]   mouse_addr;
   logic [7:0]   mouse_handler;
   logic [15:0]  kbd_led;
   logic [7:0]   kbd_addr;
   logic [7:0]   kbd_handler;
   logic [127:0] key_down;

   bus_event_type      pending_events [$];
   adb_pkg::reply_type expected_replies [$];

   int  sender_idle_pct;
   int  receiver_idle_pct;
   int  holds_asked;
   int  holds_served;
   int  hold_left;
   int  mismatches;
   int  items_accepted;
   int  replies_checked;
   int  data_replies;
   int  type_writes;
   int  cycles;
   logic req_fired;
   logic [7:0][7:0] got_bytes;
   adb_pkg::reply_type want;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(string field, int got, int exp_val);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("MISMATCH at reply %0d, %s: got 0x%0h, expected 0x%0h",
                  replies_checked, field, got, exp_val);
   endtask

   function automatic void reload_devices();
      mouse_addr    = adb_pkg::MOUSE_ADDR_RESET;
      mouse_handler = adb_pkg::MOUSE_HANDLER_RESET;
      kbd_led       = adb_pkg::KBD_LED_RESET;
      kbd_addr      = adb_pkg::KBD_ADDR_RESET;
      kbd_handler   = kbd_type;
   endfunction

   function automatic logic [7:0] listen_address(logic [7:0] cur, logic [7:0] hi,
                                                 logic [7:0] lo);
      if (lo == adb_pkg::LISTEN_ADDR_ONLY)
         return {cur[7:4], hi[3:0]};
      if (lo == adb_pkg::LISTEN_ADDR_FLAGS)
         return (cur & adb_pkg::ADDR_KEEP_MASK) | (hi & adb_pkg::ADDR_SET_MASK);
      return cur;
   endfunction

   function automatic adb_pkg::reply_type predict_reply(bus_event_type ev);
      adb_pkg::reply_type r;
      logic [3:0] adr;
      logic [1:0] cmd;
      logic [1:0] rg;
      logic [7:0] h;
      logic [7:0] l;
      r   = '0;
      adr = ev.command[7:4];
      cmd = ev.command[3:2];
      rg  = ev.command[1:0];
      case (ev.mode)
         adb_pkg::MODE_PRESS: key_down[ev.key] = 1'b1;
         adb_pkg::MODE_RELEASE: key_down[ev.key] = 1'b0;
         adb_pkg::MODE_BUS: begin
            if (ev.command[3:0] == 4'd0) begin
               reload_devices();
            end else if (adr == mouse_addr[3:0]) begin
               if (cmd == adb_pkg::CMD_LISTEN && rg == adb_pkg::REG_THREE) begin
                  if (ev.lo == adb_pkg::HANDLER_ONE || ev.lo == adb_pkg::HANDLER_TWO ||
                      ev.lo == adb_pkg::HANDLER_FOUR)
                     mouse_handler = ev.lo;
                  else
                     mouse_addr = listen_address(mouse_addr, ev.hi, ev.lo);
               end else if (cmd == adb_pkg::CMD_TALK && rg == adb_pkg::REG_ONE) begin
                  r.count    = adb_pkg::REPLY_ID;
                  r.bytes[0] = 8'h61;
                  r.bytes[1] = 8'h70;
                  r.bytes[2] = 8'h70;
                  r.bytes[3] = 8'h6c;
                  r.bytes[4] = 8'h01;
                  r.bytes[5] = 8'h2c;
                  r.bytes[6] = 8'h01;
                  r.bytes[7] = 8'h03;
               end else if (cmd == adb_pkg::CMD_TALK && rg == adb_pkg::REG_THREE) begin
                  r.count    = adb_pkg::REPLY_REG;
                  r.bytes[0] = {mouse_addr[7:4], ev.rnd};
                  r.bytes[1] = mouse_handler;
               end
            end else if (adr == kbd_addr[3:0]) begin
               if (cmd == adb_pkg::CMD_LISTEN && rg == adb_pkg::REG_TWO) begin
                  kbd_led = {ev.hi, ev.lo};
               end else if (cmd == adb_pkg::CMD_LISTEN && rg == adb_pkg::REG_THREE) begin
                  kbd_addr = listen_address(kbd_addr, ev.hi, ev.lo);
               end else if (cmd == adb_pkg::CMD_TALK && rg == adb_pkg::REG_TWO) begin
                  h = 8'hff;
                  l = kbd_led[7:0] | adb_pkg::LED_FORCE_MASK;
                  if (key_down[adb_pkg::KEY_SCROLL])  l[6] = 1'b0;
                  if (key_down[adb_pkg::KEY_NUMLOCK]) l[7] = 1'b0;
                  if (key_down[adb_pkg::KEY_COMMAND]) h[0] = 1'b0;
                  if (key_down[adb_pkg::KEY_OPTION])  h[1] = 1'b0;
                  if (key_down[adb_pkg::KEY_SHIFT])   h[2] = 1'b0;
                  if (key_down[adb_pkg::KEY_CONTROL]) h[3] = 1'b0;
                  if (key_down[adb_pkg::KEY_CAPS])    h[5] = 1'b0;
                  if (key_down[adb_pkg::KEY_DELETE])  h[6] = 1'b0;
                  r.count    = adb_pkg::REPLY_REG;
                  r.bytes[0] = h;
                  r.bytes[1] = l;
               end else if (cmd == adb_pkg::CMD_TALK && rg == adb_pkg::REG_THREE) begin
                  r.count    = adb_pkg::REPLY_REG;
                  r.bytes[0] = {kbd_addr[7:4], ev.rnd};
                  r.bytes[1] = kbd_handler;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic bus_event_type random_event();
      bus_event_type ev;
      int            pick;
      logic [3:0]    adr;
      logic [1:0]    cmd;
      ev.mode    = adb_pkg::MODE_BUS;
      ev.command = 8'($urandom);
      ev.hi      = 8'($urandom);
      ev.lo      = 8'($urandom);
      ev.key     = 7'($urandom);
      ev.rnd     = 4'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) begin
         ev.mode = (pick < 15) ? adb_pkg::MODE_PRESS : adb_pkg::MODE_RELEASE;
         if ($urandom_range(1) == 1)
            ev.key = MODIFIER_KEYS[$urandom_range(7)];
      end else if (pick < 33) begin
         ev.mode = MODE_UNUSED;
      end else begin
         pick = $urandom_range(99);
         adr  = (pick < 45) ? mouse_addr[3:0] : (pick < 90) ? kbd_addr[3:0] : 4'($urandom);
         pick = $urandom_range(99);
         cmd  = (pick < 45) ? adb_pkg::CMD_TALK : (pick < 85) ? adb_pkg::CMD_LISTEN :
                (pick < 93) ? CMD_FLUSH : CMD_RESERVED;
         ev.command = {adr, cmd, 2'($urandom)};
         if ($urandom_range(99) < 6)
            ev.command[3:0] = 4'd0;
         case ($urandom_range(5))
            0: ev.lo = adb_pkg::LISTEN_ADDR_ONLY;
            1: ev.lo = adb_pkg::LISTEN_ADDR_FLAGS;
            2: ev.lo = adb_pkg::HANDLER_ONE;
            3: ev.lo = adb_pkg::HANDLER_TWO;
            4: ev.lo = adb_pkg::HANDLER_FOUR;
            default: ;
         endcase
      end
      return ev;
   endfunction

   task automatic queue_cmd(logic [3:0] adr, logic [1:0] cmd, logic [1:0] rg,
                            logic [7:0] hi, logic [7:0] lo, logic [3:0] rnd);
      pending_events.push_back('{adb_pkg::MODE_BUS, {adr, cmd, rg}, hi, lo, 7'd0, rnd});
   endtask

   task automatic queue_key(logic [1:0] mode, logic [6:0] key);
      pending_events.push_back('{mode, 8'h00, 8'h00, 8'h00, key, 4'h0});
   endtask

   task automatic feed_random(int count);
      repeat (count) begin
         while (pending_events.size() >= FEED_AHEAD)
            @(posedge clock);
         pending_events.push_back(random_event());
      end
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_events.size() != 0 || req_if.valid || expected_replies.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_keyboard_type(logic [7:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      kbd_type = value;
      type_writes++;
   endtask

   // request driver: hold until accepted, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fired) begin
         if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            {req_if.mode, req_if.command_byte, req_if.listen_high, req_if.listen_low,
             req_if.key_number, req_if.random_nibble} <= pending_events.pop_front();
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response ready, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (holds_served < holds_asked) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= LONG_HOLD;
         holds_served <= holds_served + 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // monitor: predict on request, check on response
   always @(posedge clock) begin
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            expected_replies.push_back(predict_reply(bus_event_type'({req_if.mode,
               req_if.command_byte, req_if.listen_high, req_if.listen_low,
               req_if.key_number, req_if.random_nibble})));
            items_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected reply, count", int'(rsp_if.reply_count), 0);
            end else begin
               want = expected_replies.pop_front();
               got_bytes = {rsp_if.reply_byte_7, rsp_if.reply_byte_6, rsp_if.reply_byte_5,
                            rsp_if.reply_byte_4, rsp_if.reply_byte_3, rsp_if.reply_byte_2,
                            rsp_if.reply_byte_1, rsp_if.reply_byte_0};
               if (rsp_if.reply_count !== want.count)
                  report_mismatch("reply_count", int'(rsp_if.reply_count), int'(want.count));
               for (int i = 0; i < 8; i++)
                  if (got_bytes[i] !== want.bytes[i])
                     report_mismatch($sformatf("reply_byte_%0d", i), int'(got_bytes[i]),
                                     int'(want.bytes[i]));
               if (want.count != adb_pkg::REPLY_NONE)
                  data_replies++;
            end
            replies_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("adb_device_command_responder verification failed");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = 8'h00;
      req_if.valid         = 1'b0;
      req_if.mode          = adb_pkg::MODE_BUS;
      req_if.command_byte  = 8'h00;
      req_if.listen_high   = 8'h00;
      req_if.listen_low    = 8'h00;
      req_if.key_number    = 7'd0;
      req_if.random_nibble = 4'h0;
      rsp_if.ready         = 1'b0;
      sender_idle_pct      = 11;
      receiver_idle_pct    = 72;
      holds_asked          = 0;
      holds_served         = 0;
      hold_left            = 0;
      mismatches           = 0;
      items_accepted       = 0;
      replies_checked      = 0;
      data_replies         = 0;
      type_writes          = 0;
      cycles               = 0;
      kbd_type             = adb_pkg::KEYBOARD_TYPE_RESET;
      key_down             = '0;
      reload_devices();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      write_keyboard_type(8'h00);

      queue_cmd(4'h3, adb_pkg::CMD_TALK, adb_pkg::REG_THREE, 8'h00, 8'h00, 4'hf);
      queue_cmd(4'h2, adb_pkg::CMD_TALK, adb_pkg::REG_THREE, 8'hff, 8'hff, 4'h0);
      queue_cmd(4'h0, CMD_FLUSH, REG_ZERO, 8'h00, 8'h00, 4'h0);
      queue_cmd(4'h2, adb_pkg::CMD_TALK, adb_pkg::REG_THREE, 8'h00, 8'h00, 4'ha);
      queue_cmd(4'h3, adb_pkg::CMD_TALK, adb_pkg::REG_ONE, 8'h00, 8'h00, 4'h0);
      queue_cmd(4'h2, adb_pkg::CMD_TALK, adb_pkg::REG_TWO, 8'h00, 8'h00, 4'h0);
      foreach (MODIFIER_KEYS[i])
         queue_key(adb_pkg::MODE_PRESS, MODIFIER_KEYS[i]);
      queue_cmd(4'h2, adb_pkg::CMD_TALK, adb_pkg::REG_TWO, 8'h00, 8'h00, 4'h0);
      queue_cmd(4'h2, adb_pkg::CMD_LISTEN, adb_pkg::REG_TWO, 8'h00, 8'h00, 4'h0);
      queue_cmd(4'h2, adb_pkg::CMD_TALK, adb_pkg::REG_TWO, 8'h00, 8'h00, 4'h0);
      queue_key(adb_pkg::MODE_PRESS, 7'd0);
      queue_key(adb_pkg::MODE_RELEASE, 7'h7f);
      queue_key(adb_pkg::MODE_RELEASE, adb_pkg::KEY_SCROLL);
      queue_cmd(4'h3, adb_pkg::CMD_LISTEN, adb_pkg::REG_THREE, 8'h00, adb_pkg::HANDLER_TWO,
                4'h0);
      queue_cmd(4'h3, adb_pkg::CMD_LISTEN, adb_pkg::REG_THREE, 8'hff,
                adb_pkg::LISTEN_ADDR_ONLY, 4'h0);
      queue_cmd(4'h3, adb_pkg::CMD_LISTEN, adb_pkg::REG_THREE, 8'hff, 8'h55, 4'h0);
      queue_cmd(4'h2, adb_pkg::CMD_LISTEN, adb_pkg::REG_THREE, 8'hff,
                adb_pkg::LISTEN_ADDR_FLAGS, 4'h0);
      queue_cmd(4'hf, adb_pkg::CMD_TALK, adb_pkg::REG_THREE, 8'h00, 8'h00, 4'h5);
      queue_cmd(4'hf, adb_pkg::CMD_TALK, adb_pkg::REG_TWO, 8'h00, 8'h00, 4'h0);
      queue_cmd(4'hf, CMD_FLUSH, adb_pkg::REG_ONE, 8'hff, 8'hff, 4'hf);
      queue_cmd(4'hf, CMD_RESERVED, REG_ZERO, 8'hff, 8'hff, 4'hf);
      pending_events.push_back('{MODE_UNUSED, 8'hff, 8'hff, 8'hff, 7'h7f, 4'hf});
      queue_cmd(4'hf, CMD_FLUSH, REG_ZERO, 8'hff, 8'hff, 4'hf);

      write_keyboard_type(8'hff);
      feed_random(RANDOM_ITEMS);

      write_keyboard_type(8'($urandom_range(1, 254)));
      sender_idle_pct   = 72;
      receiver_idle_pct = 11;
      feed_random(RANDOM_ITEMS);

      write_keyboard_type(adb_pkg::KEYBOARD_TYPE_RESET);
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      feed_random(RANDOM_ITEMS / 3);
      holds_asked = 1;
      feed_random(RANDOM_ITEMS - RANDOM_ITEMS / 3);

      drain();
      repeat (8) @(posedge clock);
      if (expected_replies.size() != 0)
         report_mismatch("replies never delivered", 0, expected_replies.size());

      $display("covered %0d transactions in, %0d replies checked, %0d with reply data",
               items_accepted, replies_checked, data_replies);
      $display("keyboard type written %0d times, %0d long response hold-off(s)",
               type_writes, holds_served);
      if (mismatches == 0)
         $display("adb_device_command_responder verification clean");
      else
         $display("adb_device_command_responder verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/adb_pkg.sv
design/adb_if.sv
design/adb_front.sv
design/adb_queue.sv
design/adb_back.sv
design/adb_device_command_responder.sv
design/adb_checker.sv
tb/sv/adb_device_command_responder_test.sv
